[sv/lsab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsab_pkg
// Shared constants, codes and types of the lidar sample angle binner.
// ----------------------------------------------------------------------------
package lsab_pkg;

  // Store geometry and probing
  localparam int ANGLE_UNITS  = 23040;
  localparam int UNITS_PER_MM = 4;
  localparam int PROBE_LIMIT  = 16;

  // Field widths
  localparam int CMD_W    = 1;
  localparam int BYTE_W   = 8;
  localparam int ANGLE_W  = 15;
  localparam int DIST_W   = 16;
  localparam int MM_W     = 14;
  localparam int QUAL_W   = 6;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 3;
  localparam int PROBE_CW = $clog2(PROBE_LIMIT + 1);

  // Number of bytes buffered before the last byte of a sample
  localparam int HEAD_BYTES = 4;

  // Largest millimetre value a result can carry
  localparam int MM_MAX = 16383;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_SCAN_EN  = 2'd0;
  localparam logic [1:0] REG_MIN_QUAL = 2'd1;
  localparam logic [1:0] REG_MAX_DIST = 2'd2;

  localparam logic [DIST_W-1:0] MAX_DIST_RST = '1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ABSORBED = 3'd0,
    ST_STORED   = 3'd1,
    ST_FILTERED = 3'd2,
    ST_BAD      = 3'd3,
    ST_DROPPED  = 3'd4,
    ST_FOUND    = 3'd5,
    ST_NONE     = 3'd6
  } status_e;

  // Control states
  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_PROBE
  } fsm_e;

  // Next bin after p, wrapping at the end of the store
  function automatic logic [ANGLE_W-1:0] next_bin(input logic [ANGLE_W-1:0] p);
    logic [ANGLE_W-1:0] r;
    if (p == ANGLE_W'(ANGLE_UNITS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

[sv/lsab_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsab_in_if / lsab_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface lsab_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsab_pkg::CMD_W-1:0]   command;
  logic [lsab_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface lsab_out_if;
  logic                          valid;
  logic                          ready;
  logic [lsab_pkg::STATUS_W-1:0] status;
  logic [lsab_pkg::ANGLE_W-1:0]  angle_unit;
  logic [lsab_pkg::MM_W-1:0]     distance_mm;

  modport source (output valid, status, angle_unit, distance_mm, input ready);
  modport sink   (input valid, status, angle_unit, distance_mm, output ready);
endinterface

[sv/lidar_sample_angle_binner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_sample_angle_binner
// Assembles 5-byte lidar scan samples, checks and filters them, keeps the
// distance of each good sample in a bin memory indexed by angle, and on a
// fetch command probes the bins after the read pointer for the next point.
// ----------------------------------------------------------------------------
// A serial byte item gives its result in the cycle after acceptance.
// A fetch item issues the read of the first bin on acceptance, then probes
// up to PROBE_LIMIT bins in turn through the single bin memory read port.
// Throughput: one item at a time; the next item is taken when the result
// register is free or being emptied.
// Reset: a clearing pass writes zero to all 23040 bins, one per cycle, during
// which no item is accepted; configuration writes are taken throughout.
module lidar_sample_angle_binner (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lsab_pkg::APB_AW-1:0] paddr,
  input  logic [lsab_pkg::APB_DW-1:0] pwdata,
  output logic [lsab_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  // Item channels
  lsab_in_if.sink                     item_i,
  lsab_out_if.source                  result_o
);
  import lsab_pkg::*;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  fsm_e                state_q, state_d;

  logic                scan_en_q;
  logic [QUAL_W-1:0]   min_qual_q;
  logic [DIST_W-1:0]   max_dist_q;

  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [BYTE_W-1:0]   part_q [HEAD_BYTES];
  logic [BYTE_W-1:0]   part_d [HEAD_BYTES];
  logic                skip_q, skip_d;
  logic [ANGLE_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [ANGLE_W-1:0]  pend_q, pend_d;
  logic [PROBE_CW-1:0] cnt_q, cnt_d;
  logic [ANGLE_W-1:0]  clr_addr_q, clr_addr_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [ANGLE_W-1:0]  out_angle_q, out_angle_d;
  logic [MM_W-1:0]     out_mm_q, out_mm_d;

  logic [DIST_W-1:0]   bin_mem [ANGLE_UNITS];
  logic [DIST_W-1:0]   rdata_q;
  logic                mem_we, mem_re;
  logic [ANGLE_W-1:0]  mem_waddr, mem_raddr;
  logic [DIST_W-1:0]   mem_wdata;

  logic                in_ready;
  logic                cfg_wr;

  logic [BYTE_W-1:0]   s_qbyte;
  logic [DIST_W-1:0]   s_aword;
  logic [DIST_W-1:0]   s_raw;
  logic [ANGLE_W-1:0]  s_angle;
  logic [QUAL_W-1:0]   s_qual;
  logic                s_bad;
  logic                s_keep;

  logic [DIST_W-1:0]   quo;
  logic [MM_W-1:0]     hit_mm;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_en_q  <= 1'b0;
      min_qual_q <= '0;
      max_dist_q <= MAX_DIST_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SCAN_EN:  scan_en_q  <= pwdata[0];
        REG_MIN_QUAL: min_qual_q <= pwdata[QUAL_W-1:0];
        REG_MAX_DIST: max_dist_q <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[3:2])
      REG_SCAN_EN:  prdata = APB_DW'(scan_en_q);
      REG_MIN_QUAL: prdata = APB_DW'(min_qual_q);
      REG_MAX_DIST: prdata = APB_DW'(max_dist_q);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sample check on the last byte
  // --------------------------------------------------------------------------
  assign s_qbyte = part_q[0];
  assign s_aword = {part_q[2], part_q[1]};
  assign s_raw   = {item_i.data_byte, part_q[3]};
  assign s_angle = s_aword[DIST_W-1:1];
  assign s_qual  = s_qbyte[BYTE_W-1:2];

  // Start bit must differ from its inverse, check bit set, angle in range,
  // nonzero distance
  assign s_bad  = (s_qbyte[0] == s_qbyte[1]) || !s_aword[0] ||
                  (int'(s_angle) >= ANGLE_UNITS) || (s_raw == '0);
  assign s_keep = (s_raw <= max_dist_q) && (s_qual >= min_qual_q);

  // Convert a found raw distance to millimetres, saturating
  assign quo    = rdata_q / DIST_W'(UNITS_PER_MM);
  assign hit_mm = (quo > DIST_W'(MM_MAX)) ? MM_W'(MM_MAX) : quo[MM_W-1:0];

  // --------------------------------------------------------------------------
  // Next state, memory control and results
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    part_d       = part_q;
    skip_d       = skip_q;
    rd_ptr_d     = rd_ptr_q;
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    clr_addr_d   = clr_addr_q;
    out_valid_d  = out_valid_q & ~result_o.ready;
    out_status_d = out_status_q;
    out_angle_d  = out_angle_q;
    out_mm_d     = out_mm_q;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = next_bin(rd_ptr_q);
    in_ready     = 1'b0;

    case (state_q)
      // Sweep zeros through the bin memory after reset
      FSM_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ANGLE_W'(ANGLE_UNITS - 1)) begin
          state_d = FSM_IDLE;
        end
      end

      FSM_IDLE: begin
        in_ready = !out_valid_q || result_o.ready;
        if (in_ready && item_i.valid) begin
          out_angle_d = '0;
          out_mm_d    = '0;
          if (item_i.command != '0) begin
            // Start probing at the bin after the read pointer
            mem_re    = 1'b1;
            mem_raddr = next_bin(rd_ptr_q);
            pend_d    = next_bin(rd_ptr_q);
            cnt_d     = PROBE_CW'(1);
            state_d   = FSM_PROBE;
          end else begin
            out_valid_d = 1'b1;
            if (!scan_en_q) begin
              out_status_d = ST_DROPPED;
            end else if (skip_q) begin
              // Drop one byte to regain alignment
              skip_d       = 1'b0;
              out_status_d = ST_DROPPED;
            end else if (idx_q >= IDX_W'(HEAD_BYTES)) begin
              idx_d = '0;
              if (s_bad) begin
                skip_d       = 1'b1;
                out_status_d = ST_BAD;
              end else if (s_keep) begin
                mem_we       = 1'b1;
                mem_waddr    = s_angle;
                mem_wdata    = s_raw;
                out_status_d = ST_STORED;
              end else begin
                out_status_d = ST_FILTERED;
              end
            end else begin
              // Hold the byte until the sample is complete
              part_d[idx_q[1:0]] = item_i.data_byte;
              idx_d              = idx_q + 1'b1;
              out_status_d       = ST_ABSORBED;
            end
          end
        end
      end

      // Check the bin read last cycle while reading the next one
      FSM_PROBE: begin
        if (rdata_q != '0) begin
          mem_we       = 1'b1;
          mem_waddr    = pend_q;
          mem_wdata    = '0;
          rd_ptr_d     = pend_q;
          out_valid_d  = 1'b1;
          out_status_d = ST_FOUND;
          out_angle_d  = pend_q;
          out_mm_d     = hit_mm;
          state_d      = FSM_IDLE;
        end else if (cnt_q == PROBE_CW'(PROBE_LIMIT)) begin
          rd_ptr_d     = pend_q;
          out_valid_d  = 1'b1;
          out_status_d = ST_NONE;
          state_d      = FSM_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = next_bin(pend_q);
          pend_d    = next_bin(pend_q);
          cnt_d     = cnt_q + 1'b1;
        end
      end

      default: begin
        state_d = FSM_CLEAR;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_CLEAR;
      idx_q        <= '0;
      for (int i = 0; i < HEAD_BYTES; i++) begin
        part_q[i] <= '0;
      end
      skip_q       <= 1'b0;
      rd_ptr_q     <= '0;
      pend_q       <= '0;
      cnt_q        <= '0;
      clr_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_ABSORBED;
      out_angle_q  <= '0;
      out_mm_q     <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      part_q       <= part_d;
      skip_q       <= skip_d;
      rd_ptr_q     <= rd_ptr_d;
      pend_q       <= pend_d;
      cnt_q        <= cnt_d;
      clr_addr_q   <= clr_addr_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_angle_q  <= out_angle_d;
      out_mm_q     <= out_mm_d;
    end
  end

  // --------------------------------------------------------------------------
  // Bin memory: one write and one registered read per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= bin_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Channel outputs
  // --------------------------------------------------------------------------
  assign item_i.ready         = in_ready;
  assign result_o.valid       = out_valid_q;
  assign result_o.status      = out_status_q;
  assign result_o.angle_unit  = out_angle_q;
  assign result_o.distance_mm = out_mm_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lidar sample angle binner. Serial bytes and
// fetch commands go in over the item channel. A local predictor tracks the
// sample assembly, the filters and the angle bin store, and every result is
// compared field by field. Both channel sides idle at random. Configuration
// changes over APB with readback happen between traffic phases.
// ----------------------------------------------------------------------------
module testbench;
  import lsab_pkg::*;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;
  localparam logic [1:0] REG_SPARE = 2'd3;

  // A fetch probes up to PROBE_LIMIT bins; leave margin on top
  localparam int SETTLE_CYCLES = PROBE_LIMIT + 4;
  localparam int LONG_HOLD     = 400;

  typedef struct packed {
    status_e             status;
    logic [ANGLE_W-1:0]  angle_unit;
    logic [MM_W-1:0]     distance_mm;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lsab_in_if  in_ch ();
  lsab_out_if out_ch ();

  lidar_sample_angle_binner dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (in_ch),
    .result_o (out_ch)
  );

  // Local copy of the configuration and the decoder state
  logic               scan_on      = 1'b0;
  logic [QUAL_W-1:0]  qual_floor   = '0;
  logic [DIST_W-1:0]  dist_ceiling = '1;
  logic [IDX_W-1:0]   byte_pos     = '0;
  logic [31:0]        sample_head  = '0;
  logic               drop_next    = 1'b0;
  logic [ANGLE_W-1:0] probe_ptr    = '0;
  logic [DIST_W-1:0]  bin_dist [ANGLE_UNITS] = '{default: '0};

  outcome_t outcomes_due[$];

  // Sender and receiver control
  bit              have_offer = 1'b0;
  logic            offer_cmd  = CMD_BYTE;
  logic [BYTE_W-1:0] offer_byte = '0;
  int              gap_left     = 0;
  int              stall_left   = 0;
  int              hold_cycles  = 0;
  bit              src_idle_en  = 1'b1;
  bit              sink_idle_en = 1'b1;
  int              items_taken  = 0;
  int              fail_count   = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("lidar_sample_angle_binner regression: fail");
    $finish;
  end

  // Work out the result of one accepted item and advance the local state
  function automatic outcome_t bin_outcome(input logic cmd, input logic [BYTE_W-1:0] b);
    outcome_t           o;
    logic [7:0]         qbyte;
    logic [15:0]        aword;
    logic [DIST_W-1:0]  raw;
    logic [ANGLE_W-1:0] ang;
    int                 mm;
    bit                 hit;
    o.status = ST_ABSORBED;
    o.angle_unit = '0;
    o.distance_mm = '0;
    hit = 1'b0;
    if (cmd == CMD_FETCH) begin
      o.status = ST_NONE;
      for (int k = 0; k < PROBE_LIMIT && !hit; k++) begin
        probe_ptr = (probe_ptr == ANGLE_W'(ANGLE_UNITS - 1)) ? '0 : probe_ptr + 1'b1;
        if (bin_dist[probe_ptr] != '0) begin
          mm = int'(bin_dist[probe_ptr]) / UNITS_PER_MM;
          if (mm > MM_MAX) mm = MM_MAX;
          o.status = ST_FOUND;
          o.angle_unit = probe_ptr;
          o.distance_mm = MM_W'(mm);
          bin_dist[probe_ptr] = '0;
          hit = 1'b1;
        end
      end
    end else if (!scan_on) begin
      o.status = ST_DROPPED;
    end else if (drop_next) begin
      drop_next = 1'b0;
      o.status = ST_DROPPED;
    end else if (byte_pos >= HEAD_BYTES) begin
      // Last byte: check the whole sample, then filter or store it
      byte_pos = '0;
      qbyte = sample_head[7:0];
      aword = sample_head[23:8];
      raw = {b, sample_head[31:24]};
      ang = aword[15:1];
      if (qbyte[0] == qbyte[1] || !aword[0] || ang >= ANGLE_UNITS || raw == '0) begin
        drop_next = 1'b1;
        o.status = ST_BAD;
      end else if (raw <= dist_ceiling && qbyte[7:2] >= qual_floor) begin
        bin_dist[ang] = raw;
        o.status = ST_STORED;
      end else begin
        o.status = ST_FILTERED;
      end
    end else begin
      sample_head[8*byte_pos +: 8] = b;
      byte_pos++;
    end
    return o;
  endfunction

  // Drive offered items at the falling edge, record acceptance at the rising
  initial begin : item_driver
    in_ch.valid = 1'b0;
    in_ch.command = CMD_BYTE;
    in_ch.data_byte = '0;
    forever begin
      @(posedge clk_i);
      if (in_ch.valid && in_ch.ready) begin
        outcomes_due.push_back(bin_outcome(in_ch.command, in_ch.data_byte));
        items_taken++;
        have_offer = 1'b0;
      end
      @(negedge clk_i);
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid = 1'b0;
      end else begin
        in_ch.valid = have_offer;
        in_ch.command = offer_cmd;
        in_ch.data_byte = offer_byte;
      end
    end
  end

  // Receiver: long hold on request, otherwise random stall bursts
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare each result with the oldest outstanding expectation
  always @(posedge clk_i) begin : check_outcomes
    outcome_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (outcomes_due.size() == 0) begin
        $error("result with no item outstanding: status %0d", out_ch.status);
        fail_count++;
      end else begin
        want = outcomes_due.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.angle_unit !== want.angle_unit) begin
          $error("angle_unit: expected %0d, got %0d", want.angle_unit, out_ch.angle_unit);
          fail_count++;
        end
        if (out_ch.distance_mm !== want.distance_mm) begin
          $error("distance_mm: expected %0d, got %0d", want.distance_mm, out_ch.distance_mm);
          fail_count++;
        end
      end
    end
  end

  // Offer one item, with an optional gap first, and wait until it is taken
  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
    if (src_idle_en && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 18);
    offer_cmd = cmd;
    offer_byte = b;
    have_offer = 1'b1;
    wait (!have_offer);
  endtask

  // Send the five bytes of one scan sample
  task automatic send_sample(input logic [QUAL_W-1:0] qual, input logic start_ok,
                             input logic check_ok, input logic [ANGLE_W-1:0] ang,
                             input logic [DIST_W-1:0] raw);
    logic start_bit;
    start_bit = 1'($urandom_range(0, 1));
    send_item(CMD_BYTE, {qual, start_ok ? ~start_bit : start_bit, start_bit});
    send_item(CMD_BYTE, {ang[6:0], check_ok});
    send_item(CMD_BYTE, ang[14:7]);
    send_item(CMD_BYTE, raw[7:0]);
    send_item(CMD_BYTE, raw[15:8]);
  endtask

  // Wait for every outstanding result, then let the block go quiet
  task automatic settle();
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write a register on an idle block and, but for the spare one, read it back
  task automatic cfg_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] want;
    settle();
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SCAN_EN: begin
        scan_on = value[0];
        want = APB_DW'(scan_on);
      end
      REG_MIN_QUAL: begin
        qual_floor = value[QUAL_W-1:0];
        want = APB_DW'(qual_floor);
      end
      REG_MAX_DIST: begin
        dist_ceiling = value[DIST_W-1:0];
        want = APB_DW'(dist_ceiling);
      end
      default: want = '0;
    endcase
    if (idx != REG_SPARE) begin
      @(negedge clk_i);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clk_i);
      penable = 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== want) begin
        $error("register %0d readback: expected %0h, got %0h", idx, want, prdata);
        fail_count++;
      end
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [ANGLE_W-1:0] ahead_of_probe(input int off);
    int a;
    a = int'(probe_ptr) + off;
    if (a >= ANGLE_UNITS) a -= ANGLE_UNITS;
    return ANGLE_W'(a);
  endfunction

  // One random step: a fetch, a stray byte, or a realigned sample
  task automatic random_item();
    int                 kind;
    logic [ANGLE_W-1:0] ang;
    logic [DIST_W-1:0]  raw;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      send_item(CMD_FETCH, 8'($urandom));
    end else if (kind < 33) begin
      send_item(CMD_BYTE, 8'($urandom));
    end else begin
      // Finish any partial sample and eat the resync byte first
      while (scan_on && (drop_next || byte_pos != 0)) send_item(CMD_BYTE, 8'($urandom));
      case ($urandom_range(0, 9))
        0: ang = '0;
        1: ang = ANGLE_W'(ANGLE_UNITS - 1);
        2, 3: ang = ANGLE_W'($urandom_range(0, ANGLE_UNITS - 1));
        default: ang = ahead_of_probe($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0: raw = '1;
        1: raw = DIST_W'($urandom_range(1, 8));
        default: raw = DIST_W'($urandom_range(1, 65535));
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 6) ang = ANGLE_W'($urandom_range(ANGLE_UNITS, 32767));
      else if (kind < 12) raw = '0;
      send_sample(QUAL_W'($urandom_range(0, 63)), !(kind >= 12 && kind < 18),
                  !(kind >= 18 && kind < 24), ang, raw);
    end
  endtask

  // Bytes are dropped while scanning is off; a partial sample survives it
  task automatic test_disabled_scan();
    logic start_bit;
    cfg_write(REG_SCAN_EN, '0);
    cfg_write(REG_MIN_QUAL, '0);
    cfg_write(REG_MAX_DIST, APB_DW'(MAX_DIST_RST));
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_FETCH, 8'h00);
    // Angle and distance at their top values, best quality
    start_bit = 1'($urandom_range(0, 1));
    cfg_write(REG_SCAN_EN, 32'd1);
    send_item(CMD_BYTE, {6'h3F, ~start_bit, start_bit});
    send_item(CMD_BYTE, {7'h7F, 1'b1});
    cfg_write(REG_SCAN_EN, '0);
    send_item(CMD_BYTE, 8'hA5);
    cfg_write(REG_SCAN_EN, 32'd1);
    send_item(CMD_BYTE, 8'(ANGLE_W'(ANGLE_UNITS - 1) >> 7));
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'hFF);
  endtask

  // A bad sample drops the next byte; then store one point and fetch it
  task automatic test_bad_and_resync();
    send_sample(6'd20, 1'b0, 1'b1, '0, 16'd100);
    send_item(CMD_BYTE, 8'h55);
    send_sample('0, 1'b1, 1'b1, ahead_of_probe(3), 16'd4);
    send_item(CMD_FETCH, 8'hFF);
    send_item(CMD_FETCH, 8'h00);
  endtask

  // A write beyond the register list must change nothing
  task automatic test_spare_register();
    cfg_write(REG_SPARE, '1);
  endtask

  // Points at the last probed bin and just past it: one fetch each, then none
  task automatic test_probe_window();
    logic [ANGLE_W-1:0] edge_bin;
    logic [ANGLE_W-1:0] past_bin;
    edge_bin = ahead_of_probe(PROBE_LIMIT);
    past_bin = ahead_of_probe(PROBE_LIMIT + 1);
    send_sample(6'd40, 1'b1, 1'b1, edge_bin, 16'd4000);
    send_sample(6'd40, 1'b1, 1'b1, past_bin, 16'd65534);
    send_item(CMD_FETCH, 8'($urandom));
    send_item(CMD_FETCH, 8'($urandom));
    send_item(CMD_FETCH, 8'($urandom));
  endtask

  // Hold the receiver off while items keep coming, so the input stalls
  task automatic test_backpressure();
    hold_cycles = LONG_HOLD;
    repeat (12) random_item();
  endtask

  task automatic run_phase(input logic scan, input logic [QUAL_W-1:0] qf,
                           input logic [DIST_W-1:0] dc, input bit idle, input int count);
    int stop_at;
    cfg_write(REG_SCAN_EN, APB_DW'(scan));
    cfg_write(REG_MIN_QUAL, APB_DW'(qf));
    cfg_write(REG_MAX_DIST, APB_DW'(dc));
    src_idle_en = idle;
    sink_idle_en = idle;
    stop_at = items_taken + count;
    while (items_taken < stop_at) random_item();
  endtask

  // Random traffic over several register settings; the last part runs calm
  task automatic test_random_traffic();
    run_phase(1'b1, '0, '1, 1'b1, 320);
    run_phase(1'b1, 6'd63, '0, 1'b1, 120);
    run_phase(1'b1, QUAL_W'($urandom_range(0, 63)), DIST_W'($urandom_range(1000, 65535)),
              1'b1, 300);
    run_phase(1'b0, 6'd10, 16'd30000, 1'b1, 40);
    run_phase(1'b1, QUAL_W'($urandom_range(0, 24)), DIST_W'($urandom_range(20000, 65535)),
              1'b1, 300);
    run_phase(1'b1, '0, '1, 1'b0, 270);
  endtask

  initial begin : run_tests
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_disabled_scan();
    test_bad_and_resync();
    test_spare_register();
    test_probe_window();
    test_backpressure();
    test_random_traffic();

    settle();
    if (fail_count == 0) begin
      $display("lidar_sample_angle_binner regression: pass");
    end else begin
      $display("lidar_sample_angle_binner regression: fail");
    end
    $finish;
  end

endmodule
